>>> hdl/iwjd_pkg.sv
`timescale 1ns / 1ps

package iwjd_pkg;

    localparam int MAX_WORKERS = 16;
    localparam int QUEUE_DEPTH = 16;
    localparam int JOB_BITS    = 8;

    localparam int WORKER_BITS = 4;
    localparam int CFG_W       = 5;
    localparam int CMD_W       = 2;
    localparam int OUTCOME_W   = 3;
    localparam int CFG_RESET   = 4;

    localparam int CNT_W   = $clog2(MAX_WORKERS + 1);
    localparam int WIDX_W  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int QADDR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam int TDATA_W = ((JOB_BITS + WORKER_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_SUBMIT   = 2'd0,
        CMD_FINISH   = 2'd1,
        CMD_SHUTDOWN = 2'd2,
        CMD_INIT     = 2'd3
    } command_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_DISPATCHED  = 3'd0,
        OUT_QUEUED      = 3'd1,
        OUT_ABANDONED   = 3'd2,
        OUT_IGNORED     = 3'd3,
        OUT_WORKER_IDLE = 3'd4,
        OUT_REJECTED    = 3'd5,
        OUT_SHUT_EMPTY  = 3'd6,
        OUT_INIT_DONE   = 3'd7
    } outcome_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_SUBMIT,
        OP_FINISH,
        OP_SHUTDOWN,
        OP_DRAIN,
        OP_FILL,
        OP_INIT_DONE
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        command_t command;
        logic     pool_ready;
        logic     queue_empty;
        logic     queue_one;
        logic     count_zero;
        logic     fill_last;
        logic     out_free;
    } dp_status_t;

endpackage

>>> hdl/iwjd_ctrl.sv
`timescale 1ns / 1ps

module iwjd_ctrl
    import iwjd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DRAIN,
        ST_FILL,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.out_free)
                begin
                    case (status.command)
                        CMD_SUBMIT:
                        begin
                            cmd.op     = OP_SUBMIT;
                            state_next = ST_IDLE;
                        end
                        CMD_FINISH:
                        begin
                            cmd.op     = OP_FINISH;
                            state_next = ST_IDLE;
                        end
                        CMD_SHUTDOWN:
                        begin
                            if (status.pool_ready && !status.queue_empty)
                            begin
                                state_next = ST_DRAIN;
                            end
                            else
                            begin
                                cmd.op     = OP_SHUTDOWN;
                                state_next = ST_IDLE;
                            end
                        end
                        default:
                        begin
                            if (status.count_zero)
                            begin
                                cmd.op     = OP_INIT_DONE;
                                state_next = ST_IDLE;
                            end
                            else
                            begin
                                state_next = ST_FILL;
                            end
                        end
                    endcase
                end
            end
            ST_DRAIN:
            begin
                if (status.out_free)
                begin
                    cmd.op = OP_DRAIN;
                    if (status.queue_one)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FILL:
            begin
                cmd.op = OP_FILL;
                if (status.fill_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_INIT_DONE;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

>>> hdl/iwjd_datapath.sv
`timescale 1ns / 1ps

module iwjd_datapath
    import iwjd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [TDATA_W-1:0]   s_tdata,
    input  logic [CMD_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,
    output logic [OUTCOME_W-1:0] m_tuser,
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,
    input  dp_cmd_t              cmd,
    output dp_status_t           status
);

    logic [WORKER_BITS-1:0] idle_stack [MAX_WORKERS];
    logic [JOB_BITS-1:0]    job_queue  [QUEUE_DEPTH];

    logic [CFG_W-1:0]   worker_count_reg;
    logic [CNT_W-1:0]   idle_count_reg,  idle_count_next;
    logic [QADDR_W-1:0] queue_head_reg,  queue_head_next;
    logic [QADDR_W-1:0] queue_tail_reg,  queue_tail_next;
    logic [QCNT_W-1:0]  queue_count_reg, queue_count_next;
    logic               pool_ready_reg,  pool_ready_next;
    logic               shutting_reg,    shutting_next;
    logic               out_valid_reg,   out_valid_next;

    command_t               in_cmd_reg;
    logic [JOB_BITS-1:0]    in_job_reg;
    logic [WORKER_BITS-1:0] in_worker_reg;
    logic [CNT_W-1:0]       init_cnt_reg;
    logic [WIDX_W-1:0]      fill_idx_reg;

    outcome_t               out_outcome_reg, out_outcome_next;
    logic [JOB_BITS-1:0]    out_job_reg,     out_job_next;
    logic [WORKER_BITS-1:0] out_worker_reg,  out_worker_next;
    logic                   out_last_reg,    out_last_next;

    logic                   emit;
    logic                   out_free;
    logic [CNT_W-1:0]       top_idx;
    logic [WORKER_BITS-1:0] stack_top;
    logic [JOB_BITS-1:0]    queue_front;
    logic                   stack_we;
    logic [WIDX_W-1:0]      stack_waddr;
    logic [WORKER_BITS-1:0] stack_wdata;
    logic                   queue_we;

    function automatic logic [QADDR_W-1:0] wrap_next(input logic [QADDR_W-1:0] p);
        return (p == QADDR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QADDR_W'(1);
    endfunction

    assign out_free    = !out_valid_reg || m_tready;
    assign top_idx     = idle_count_reg - CNT_W'(1);
    assign stack_top   = idle_stack[top_idx[WIDX_W-1:0]];
    assign queue_front = job_queue[queue_head_reg];

    assign emit = (cmd.op == OP_SUBMIT) || (cmd.op == OP_FINISH) ||
                  (cmd.op == OP_SHUTDOWN) || (cmd.op == OP_DRAIN) ||
                  (cmd.op == OP_INIT_DONE);

    always_comb
    begin
        idle_count_next  = idle_count_reg;
        queue_head_next  = queue_head_reg;
        queue_tail_next  = queue_tail_reg;
        queue_count_next = queue_count_reg;
        pool_ready_next  = pool_ready_reg;
        shutting_next    = shutting_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_outcome_next = out_outcome_reg;
        out_job_next     = out_job_reg;
        out_worker_next  = out_worker_reg;
        out_last_next    = out_last_reg;
        stack_we         = 1'b0;
        stack_waddr      = fill_idx_reg;
        stack_wdata      = WORKER_BITS'(fill_idx_reg);
        queue_we         = 1'b0;

        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_last_next   = 1'b1;
            out_job_next    = '0;
            out_worker_next = '0;
        end

        case (cmd.op)
            OP_SUBMIT:
            begin
                out_job_next = in_job_reg;
                if (!pool_ready_reg)
                begin
                    out_outcome_next = OUT_IGNORED;
                end
                else if (shutting_reg)
                begin
                    out_outcome_next = OUT_ABANDONED;
                end
                else if (idle_count_reg != '0)
                begin
                    idle_count_next  = top_idx;
                    out_outcome_next = OUT_DISPATCHED;
                    out_worker_next  = stack_top;
                end
                else if (int'(queue_count_reg) < QUEUE_DEPTH)
                begin
                    queue_we         = 1'b1;
                    queue_tail_next  = wrap_next(queue_tail_reg);
                    queue_count_next = queue_count_reg + QCNT_W'(1);
                    out_outcome_next = OUT_QUEUED;
                end
                else
                begin
                    out_outcome_next = OUT_REJECTED;
                end
            end
            OP_FINISH:
            begin
                out_worker_next = in_worker_reg;
                if (!pool_ready_reg)
                begin
                    out_outcome_next = OUT_IGNORED;
                end
                else if (queue_count_reg != '0)
                begin
                    queue_head_next  = wrap_next(queue_head_reg);
                    queue_count_next = queue_count_reg - QCNT_W'(1);
                    out_outcome_next = OUT_DISPATCHED;
                    out_job_next     = queue_front;
                end
                else if (int'(idle_count_reg) < MAX_WORKERS)
                begin
                    stack_we         = 1'b1;
                    stack_waddr      = idle_count_reg[WIDX_W-1:0];
                    stack_wdata      = in_worker_reg;
                    idle_count_next  = idle_count_reg + CNT_W'(1);
                    out_outcome_next = OUT_WORKER_IDLE;
                end
                else
                begin
                    out_outcome_next = OUT_IGNORED;
                end
            end
            OP_SHUTDOWN:
            begin
                if (!pool_ready_reg)
                begin
                    out_outcome_next = OUT_IGNORED;
                end
                else
                begin
                    shutting_next    = 1'b1;
                    queue_head_next  = '0;
                    queue_tail_next  = '0;
                    out_outcome_next = OUT_SHUT_EMPTY;
                end
            end
            OP_DRAIN:
            begin
                shutting_next    = 1'b1;
                out_outcome_next = OUT_ABANDONED;
                out_job_next     = queue_front;
                out_last_next    = status.queue_one;
                queue_count_next = queue_count_reg - QCNT_W'(1);
                if (status.queue_one)
                begin
                    queue_head_next = '0;
                    queue_tail_next = '0;
                end
                else
                begin
                    queue_head_next = wrap_next(queue_head_reg);
                end
            end
            OP_FILL:
            begin
                stack_we = 1'b1;
            end
            OP_INIT_DONE:
            begin
                idle_count_next  = init_cnt_reg;
                queue_head_next  = '0;
                queue_tail_next  = '0;
                queue_count_next = '0;
                shutting_next    = 1'b0;
                pool_ready_next  = (init_cnt_reg != '0);
                out_outcome_next = OUT_INIT_DONE;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            worker_count_reg <= CFG_W'(CFG_RESET);
            idle_count_reg   <= '0;
            queue_head_reg   <= '0;
            queue_tail_reg   <= '0;
            queue_count_reg  <= '0;
            pool_ready_reg   <= 1'b0;
            shutting_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                worker_count_reg <= cfg_data;
            end
            idle_count_reg  <= idle_count_next;
            queue_head_reg  <= queue_head_next;
            queue_tail_reg  <= queue_tail_next;
            queue_count_reg <= queue_count_next;
            pool_ready_reg  <= pool_ready_next;
            shutting_reg    <= shutting_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_outcome_reg <= out_outcome_next;
        out_job_reg     <= out_job_next;
        out_worker_reg  <= out_worker_next;
        out_last_reg    <= out_last_next;
        if (cmd.op == OP_LOAD)
        begin
            in_cmd_reg    <= command_t'(s_tuser);
            in_job_reg    <= s_tdata[JOB_BITS-1:0];
            in_worker_reg <= s_tdata[JOB_BITS +: WORKER_BITS];
            init_cnt_reg  <= (int'(worker_count_reg) > MAX_WORKERS) ?
                             CNT_W'(MAX_WORKERS) : CNT_W'(worker_count_reg);
            fill_idx_reg  <= '0;
        end
        else if (cmd.op == OP_FILL)
        begin
            fill_idx_reg <= fill_idx_reg + WIDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            idle_stack[stack_waddr] <= stack_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (queue_we)
        begin
            job_queue[queue_tail_reg] <= in_job_reg;
        end
    end

    assign status.command     = in_cmd_reg;
    assign status.pool_ready  = pool_ready_reg;
    assign status.queue_empty = (queue_count_reg == '0);
    assign status.queue_one   = (queue_count_reg == QCNT_W'(1));
    assign status.count_zero  = (init_cnt_reg == '0);
    assign status.fill_last   = ((CNT_W'(fill_idx_reg) + CNT_W'(1)) == init_cnt_reg);
    assign status.out_free    = out_free;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_outcome_reg;
    assign m_tlast   = out_last_reg;
    assign m_tdata   = TDATA_W'({out_worker_reg, out_job_reg});

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(queue_count_reg) <= QUEUE_DEPTH)
        else $error("queue count beyond depth");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(idle_count_reg) <= MAX_WORKERS)
        else $error("idle count beyond pool size");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result issued over an untaken result");

    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_DRAIN && status.queue_one) |=>
            (queue_count_reg == '0 && queue_head_reg == '0 && m_tlast))
        else $error("drain did not end with empty queue and last");

endmodule

>>> hdl/idle_worker_job_dispatcher.sv
`timescale 1ns / 1ps
// Submit and worker-finished requests: accepted into the input registers, executed
// once the output register is free, which registers the result; no new request is
// taken until the last is executed. Shutdown drains the N queued jobs (one result per
// cycle from the FIFO read port while the output is free); init sweeps worker_count
// stack entries (count saturated at 16; no sweep with count zero). Reset (rst_n, async,
// active low): pool not initialised, stack and FIFO empty, worker_count 4; contents kept.

module idle_worker_job_dispatcher
    import iwjd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,   // job_id, worker_id
    input  logic [CMD_W-1:0]     s_tuser,   // command
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // out_job, out_worker
    output logic [OUTCOME_W-1:0] m_tuser,   // outcome
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    iwjd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    iwjd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
